// ===== rtl/core/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round functions of the MD5 engine.
// ----------------------------------------------------------------------------
package md5_pkg;

   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int BLK_WRDS = 16;
   localparam int LEN_W   = 64;

   typedef logic [WORD_W-1:0] md5_word_type;

   // Command from the fill controller to the compression engine
   typedef struct packed {
      logic start;   // compress the block now held in the buffer
      logic init;    // reload the chaining values with the initial vector
   } md5_cmd_type;

   // Status from the compression engine
   typedef struct packed {
      logic done;    // chaining values updated this cycle
      logic idle;    // no compression in flight
   } md5_stat_type;

   localparam md5_word_type CHAIN_INIT [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam md5_word_type SINE_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word used by a given round
   function automatic logic [3:0] msg_sel(input logic [5:0] rnd);
      logic [3:0] r;
      logic [3:0] s;
      r = rnd[3:0];
      unique case (rnd[5:4])
         2'd0:    s = r;
         2'd1:    s = 4'(r * 4'd5 + 4'd1);
         2'd2:    s = 4'(r * 4'd3 + 4'd5);
         default: s = 4'(r * 4'd7);
      endcase
      return s;
   endfunction

   // Left rotate by a non-zero amount
   function automatic md5_word_type rot_left(input md5_word_type v, input logic [4:0] n);
      logic [2*WORD_W-1:0] dbl;
      dbl = {v, v} << n;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

endpackage

// ===== rtl/core/md5_if.sv =====
// ----------------------------------------------------------------------------
// md5_req_if / md5_rsp_if
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       last_byte;

   modport source (output valid, data_byte, byte_present, last_byte, input ready);
   modport sink   (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/core/md5_ram.sv =====
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/core/md5_compress.sv =====
// ----------------------------------------------------------------------------
// md5_compress
// One MD5 round per cycle over the buffered block; owns the chaining values.
// ----------------------------------------------------------------------------
module md5_compress
   import md5_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  md5_cmd_type  cmd,
   output md5_stat_type stat,
   output logic         rd_en,
   output logic [3:0]   rd_addr,
   input  md5_word_type rd_data,
   output md5_word_type chain_out [4]
);

   localparam logic [1:0] P_IDLE  = 2'd0;
   localparam logic [1:0] P_PREF  = 2'd1;
   localparam logic [1:0] P_ROUND = 2'd2;
   localparam logic [1:0] P_FIN   = 2'd3;

   logic [1:0]   phase_ff, phase_in;
   logic [5:0]   round_ff, round_in;
   md5_word_type a_ff, b_ff, c_ff, d_ff;
   md5_word_type chain_ff [4];
   md5_word_type mix, sum, new_b;

   always_comb begin
      case (round_ff[5:4])
         2'd0:    mix = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    mix = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2:    mix = b_ff ^ c_ff ^ d_ff;
         default: mix = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum   = a_ff + mix + SINE_TABLE[round_ff] + rd_data;
      new_b = b_ff + rot_left(sum, ROT_TABLE[{round_ff[5:4], round_ff[1:0]}]);
   end

   // Fetch the word of the coming round in the cycle before that round
   assign rd_en   = (phase_ff == P_PREF) || (phase_ff == P_ROUND);
   assign rd_addr = (phase_ff == P_PREF) ? msg_sel(6'd0) : msg_sel(6'(round_ff + 6'd1));

   assign stat.done = (phase_ff == P_FIN);
   assign stat.idle = (phase_ff == P_IDLE);

   always_comb begin
      phase_in = phase_ff;
      round_in = round_ff;
      unique case (phase_ff)
         P_IDLE: begin
            if (cmd.start) phase_in = P_PREF;
         end
         P_PREF: begin
            phase_in = P_ROUND;
            round_in = '0;
         end
         P_ROUND: begin
            round_in = 6'(round_ff + 6'd1);
            if (round_ff == 6'd63) phase_in = P_FIN;
         end
         default: phase_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         round_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) chain_ff[i] <= CHAIN_INIT[i];
      end else if (phase_ff == P_FIN) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
      end else if (cmd.init) begin
         for (int i = 0; i < 4; i++) chain_ff[i] <= CHAIN_INIT[i];
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff == P_PREF) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (phase_ff == P_ROUND) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= new_b;
      end
   end

   assign chain_out = chain_ff;

endmodule

// ===== rtl/core/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest
// Byte-serial MD5 hasher: buffers 64-byte blocks, pads, outputs the digest.
// ----------------------------------------------------------------------------
// Throughput: one message byte per cycle; every 64th byte stalls input
//   while the round engine runs one round per cycle.
// Last transaction: padding fills the rest of the block (one more block when
//   the length field does not fit), each block is then compressed, and the
//   four digest words follow, one per cycle while the sink is ready.
// Reset: synchronous; clears control, length and chaining values. The block
//   buffer RAM is not cleared and is only read after being written.
// ----------------------------------------------------------------------------
module md5_message_digest
   import md5_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   md5_req_if.sink      req_bus,
   md5_rsp_if.source    rsp_bus
);

   localparam logic [1:0] S_IDLE = 2'd0;   // take message bytes
   localparam logic [1:0] S_PAD  = 2'd1;   // generate padding bytes
   localparam logic [1:0] S_COMP = 2'd2;   // wait for the round engine
   localparam logic [1:0] S_OUT  = 2'd3;   // hand out the digest words

   logic [1:0]       state_ff, state_in;
   logic [5:0]       pos_ff, pos_in;       // byte position within the block
   logic [23:0]      asm_ff, asm_in;       // bytes gathered for the current word
   logic [LEN_W-1:0] len_ff, len_in;       // message byte count
   logic [1:0]       idx_ff, idx_in;
   logic             pad_ff, pad_in;       // padding owed or under way
   logic             mark_ff, mark_in;     // 0x80 byte still to go
   logic             lenok_ff, lenok_in;   // length field goes in this block
   logic             final_ff, final_in;   // running compression is the last one

   logic             push;
   logic [7:0]       push_byte;
   logic [LEN_W-1:0] bit_len;
   logic             req_take, rsp_take;

   md5_cmd_type      cmd;
   md5_stat_type     stat;
   logic             rd_en;
   logic [3:0]       rd_addr;
   md5_word_type     rd_data;
   md5_word_type     chain [4];

   assign req_bus.ready = (state_ff == S_IDLE) && stat.idle;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_take      = rsp_bus.valid && rsp_bus.ready;
   assign bit_len       = {len_ff[LEN_W-4:0], 3'b000};

   // Byte source: the message in idle, the padding pattern while padding, none otherwise
   always_comb begin
      push      = 1'b0;
      push_byte = req_bus.data_byte;
      if (state_ff == S_IDLE) begin
         push = req_take && req_bus.byte_present;
      end else if (state_ff == S_PAD) begin
         push = 1'b1;
         if (mark_ff) begin
            push_byte = 8'h80;
         end else if (lenok_ff && (pos_ff[5:3] == 3'd7)) begin
            push_byte = bit_len[{pos_ff[2:0], 3'b000} +: 8];
         end else begin
            push_byte = 8'h00;
         end
      end
   end

   // Gather little-endian words; the fourth byte completes a buffer write
   assign asm_in = push ? {push_byte, asm_ff[23:8]} : asm_ff;
   assign pos_in = push ? 6'(pos_ff + 6'd1) : pos_ff;

   md5_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BLK_WRDS)
   ) u_buf (
      .clock   (clock),
      .wr_en   (push && (pos_ff[1:0] == 2'd3)),
      .wr_addr (pos_ff[5:2]),
      .wr_data ({push_byte, asm_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   md5_compress u_comp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .chain_out (chain)
   );

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      pad_in     = pad_ff;
      mark_in    = mark_ff;
      lenok_in   = lenok_ff;
      final_in   = final_ff;
      cmd.start  = 1'b0;
      cmd.init   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_bus.byte_present) len_in = len_ff + LEN_W'(1);
               // Arm padding on the last transaction
               if (req_bus.last_byte) begin
                  pad_in   = 1'b1;
                  mark_in  = 1'b1;
                  lenok_in = 1'b0;
               end
               if (push && (pos_ff == 6'd63)) begin
                  cmd.start = 1'b1;
                  final_in  = 1'b0;
                  state_in  = S_COMP;
               end else if (req_bus.last_byte) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            mark_in = 1'b0;
            if (mark_ff && (pos_ff[5:3] != 3'd7)) lenok_in = 1'b1;
            if (pos_ff == 6'd63) begin
               // Block full: compress; the length lands in the next one at latest
               cmd.start = 1'b1;
               final_in  = lenok_ff && !mark_ff;
               lenok_in  = 1'b1;
               state_in  = S_COMP;
            end
         end
         S_COMP: begin
            if (stat.done) begin
               if (final_ff) begin
                  idx_in   = '0;
                  state_in = S_OUT;
               end else if (pad_ff) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            if (rsp_take) begin
               idx_in = 2'(idx_ff + 2'd1);
               if (idx_ff == 2'd3) begin
                  // Digest delivered: reinitialise for the next message
                  cmd.init = 1'b1;
                  len_in   = '0;
                  pad_in   = 1'b0;
                  final_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
         idx_ff   <= '0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         lenok_ff <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         lenok_ff <= lenok_in;
         final_ff <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      asm_ff <= asm_in;
   end

   // Chaining values hold still while the words are handed out
   assign rsp_bus.valid       = (state_ff == S_OUT);
   assign rsp_bus.digest_word = chain[idx_ff];
   assign rsp_bus.word_index  = idx_ff;
   assign rsp_bus.last_word   = (idx_ff == 2'd3);

endmodule

// ===== rtl/core/md5_checker.sv =====
// ----------------------------------------------------------------------------
// md5_checker
// Port-level checks on the MD5 engine, bound to the top level.
// ----------------------------------------------------------------------------
module md5_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [1:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // Stalled digest word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word))
      else $error("digest word changed while stalled");

   // Words follow in order without a gap
   a_rsp_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word
      |=> rsp_valid && (rsp_word_index == 2'($past(rsp_word_index) + 2'd1)))
      else $error("digest words out of order");

   // Final flag marks the fourth word only
   a_rsp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 2'd3)))
      else $error("last word flag mismatch");

   // No byte taken while the digest is out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(req_valid && req_ready))
      else $error("input accepted during digest output");

   // Input reopens right after the digest
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_word |=> req_ready)
      else $error("input not ready after digest");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_digest_word (rsp_bus.digest_word),
   .rsp_word_index  (rsp_bus.word_index),
   .rsp_last_word   (rsp_bus.last_word)
);

// ===== test/md5_digest_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_digest_check
// Watches the byte and digest channels of the MD5 hasher. Every accepted
// byte transaction is folded into a local MD5 state; each end of message
// queues the four expected chaining words, and every accepted digest
// transaction is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module md5_digest_check
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   md5_req_if          req_bus,
   md5_rsp_if          rsp_bus,
   output int unsigned fail_count,
   output int unsigned pending_count
);

   localparam md5_word_type H_START [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam md5_word_type ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROUND_SHIFT [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   typedef struct packed {
      md5_word_type word;
      logic [1:0]   index;
      logic         is_last;
   } digest_word_type;

   md5_word_type    hash_state [4];
   logic [7:0]      blk_bytes [64];
   logic [63:0]     byte_count;
   digest_word_type digest_q [$];

   function automatic md5_word_type rotl32(input md5_word_type v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void compress_block();
      md5_word_type m [16];
      md5_word_type a, b, c, d, f, t;
      int g;
      for (int j = 0; j < 16; j++)
         m[j] = {blk_bytes[4*j+3], blk_bytes[4*j+2], blk_bytes[4*j+1], blk_bytes[4*j]};
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (d & b) | (~d & c);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         t = d;
         d = c;
         c = b;
         b = b + rotl32(a + f + ROUND_K[r] + m[g], ROUND_SHIFT[(r / 16) * 4 + r % 4]);
         a = t;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
   endfunction

   function automatic void restart_digest();
      for (int j = 0; j < 4; j++)
         hash_state[j] = H_START[j];
      byte_count = '0;
   endfunction

   // Fold one byte transaction in; on end of message pad, finish and queue the digest.
   function automatic void absorb_byte(input logic [7:0] data, input logic present,
                                       input logic is_last);
      int pos;
      logic [63:0] bit_len;
      digest_word_type e;
      if (present) begin
         blk_bytes[byte_count[5:0]] = data;
         byte_count++;
         if (byte_count[5:0] == 6'd0)
            compress_block();
      end
      if (!is_last)
         return;
      pos = int'(byte_count[5:0]);
      blk_bytes[pos] = 8'h80;
      for (int j = pos + 1; j < 64; j++)
         blk_bytes[j] = 8'h00;
      // no room for the length field: spill into one more block
      if (pos >= 56) begin
         compress_block();
         for (int j = 0; j < 56; j++)
            blk_bytes[j] = 8'h00;
      end
      bit_len = byte_count << 3;
      for (int j = 0; j < 8; j++)
         blk_bytes[56 + j] = bit_len[8*j +: 8];
      compress_block();
      for (int j = 0; j < 4; j++) begin
         e.word    = hash_state[j];
         e.index   = 2'(j);
         e.is_last = (j == 3);
         digest_q.push_back(e);
      end
      restart_digest();
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: digest mismatch on %s: got 0x%h, expected 0x%h",
               $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      digest_word_type want;
      if (reset) begin
         restart_digest();
         digest_q.delete();
         fail_count    = 0;
         pending_count = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (digest_q.size() == 0) begin
               report_mismatch("word with no digest pending", rsp_bus.digest_word, '0);
            end else begin
               want = digest_q.pop_front();
               if (rsp_bus.digest_word !== want.word)
                  report_mismatch("digest_word", rsp_bus.digest_word, want.word);
               if (rsp_bus.word_index !== want.index)
                  report_mismatch("word_index", 32'(rsp_bus.word_index), 32'(want.index));
               if (rsp_bus.last_word !== want.is_last)
                  report_mismatch("last_word", 32'(rsp_bus.last_word), 32'(want.is_last));
            end
         end
         if (req_bus.valid && req_bus.ready)
            absorb_byte(req_bus.data_byte, req_bus.byte_present, req_bus.last_byte);
         pending_count = digest_q.size();
      end
   end

endmodule

// ===== test/md5_message_digest_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_message_digest_tb
// Feeds the byte-serial MD5 hasher with messages of many lengths and with
// random stalls on both channels; a checker beside the block predicts and
// compares every digest word, and this module gives the verdict.
// ----------------------------------------------------------------------------
module md5_message_digest_tb;

   // Allow far more cycles than a correct run with the heaviest stalls needs.
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned ITEM_TARGET  = 400;
   // two blocks of rounds plus a full padding pass, with margin
   localparam int unsigned DRAIN_CYCLES = 300;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;
   int unsigned item_count  = 0;
   int unsigned src_idle_pct  = 0;
   int unsigned sink_idle_pct = 0;

   md5_req_if req_bus ();
   md5_rsp_if rsp_bus ();

   md5_message_digest uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   md5_digest_check digest_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop: a hung handshake must not run for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL md5_message_digest");
         $finish;
      end
   end

   // Stall the digest channel at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
   end

   // Pick the idle rates from progress: receiver-heavy gaps, then sender-heavy,
   // then full speed on both sides.
   function automatic void set_idle_phase();
      if (item_count < ITEM_TARGET / 3) begin
         src_idle_pct  = 38;
         sink_idle_pct = 56;
      end else if (item_count < 2 * ITEM_TARGET / 3) begin
         src_idle_pct  = 56;
         sink_idle_pct = 38;
      end else begin
         src_idle_pct  = 0;
         sink_idle_pct = 0;
      end
   endfunction

   // Drive one byte transaction and hold it until the block takes it.
   // Valid is only ever lowered in an idle gap, never in the step that raises it.
   task automatic send_item(input logic [7:0] data, input logic present, input logic is_last);
      set_idle_phase();
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.data_byte    <= data;
      req_bus.byte_present <= present;
      req_bus.last_byte    <= is_last;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (present || is_last)
         item_count++;
   endtask

   // Send a message of random content. With last_alone the end of message rides
   // on a transaction carrying no byte; noisy scatters ignored transactions in.
   task automatic send_message(input int len, input bit last_alone, input bit noisy);
      for (int i = 0; i < len; i++) begin
         if (noisy && $urandom_range(99) < 10)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, (i == len - 1) && !last_alone);
      end
      if (len == 0 || last_alone)
         send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      int len;
      int pick;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.data_byte    = '0;
      req_bus.byte_present = 1'b0;
      req_bus.last_byte    = 1'b0;
      rsp_bus.ready        = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: an ignored transaction, the empty message, single bytes at the
      // extremes, an end of message with no byte, and the classic "abc".
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h3c, 1'b0, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'hff, 1'b0, 1'b1);

      // Block boundaries: length field just fits, padding spills over (twice),
      // and an exactly full block followed by a padding-only block.
      send_message(55, 1'b0, 1'b1);
      send_message(56, 1'b1, 1'b1);
      send_message(63, 1'b0, 1'b1);
      send_message(64, 1'b1, 1'b1);

      // Random messages, mostly short so that digests come often.
      while (item_count < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 65)
            len = $urandom_range(8, 0);
         else if (pick < 90)
            len = $urandom_range(30, 9);
         else
            len = $urandom_range(70, 40);
         send_message(len, $urandom_range(2) == 0, 1'b1);
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // Drain: wait for every queued digest word, then watch for strays.
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0)
         $display("PASS md5_message_digest");
      else
         $display("FAIL md5_message_digest");
      $finish;
   end

endmodule
